// ----- rtl/core/dcri_pkg.sv -----
// shared types, codes and constants for the disk controller register interface
// no dependencies; imported by every module of the block

package dcri_pkg;

    // register file layout
    localparam int RF_DEPTH = 12;
    localparam int RF_IDX_W = 4;
    localparam logic [RF_IDX_W-1:0] RF_ADDR_LO   = 4'd0;
    localparam logic [RF_IDX_W-1:0] RF_ADDR_MID  = 4'd1;
    localparam logic [RF_IDX_W-1:0] RF_ADDR_HI   = 4'd2;
    localparam logic [RF_IDX_W-1:0] RF_SECTOR    = 4'd3;
    localparam logic [RF_IDX_W-1:0] RF_HEAD_CYL  = 4'd4;
    localparam logic [RF_IDX_W-1:0] RF_CYL_LO    = 4'd5;
    localparam logic [RF_IDX_W-1:0] RF_TERM      = 4'd9;
    localparam logic [RF_IDX_W-1:0] RF_CHIP_STAT = 4'd10;
    localparam logic [RF_IDX_W-1:0] RF_DRV_STAT  = 4'd11;
    // data port reaches pointer values below this one
    localparam logic [RF_IDX_W-1:0] PTR_LIMIT    = 4'd10;
    // pointer values from here on map to the status copies
    localparam logic [RF_IDX_W-1:0] PTR_STAT_MAP = 4'd8;
    localparam logic [RF_IDX_W-1:0] PTR_STAT_OFS = 4'd2;

    // status byte bits
    localparam logic [7:0] ST_PENDING = 8'h80;
    localparam logic [7:0] ST_DONE    = 8'h20;
    localparam logic [7:0] ST_CODE_ERR = 8'h08;

    // termination condition bits
    localparam int TERM_IRQ_BIT = 5;
    localparam int TERM_WP_BIT  = 2;

    // drive status forming
    localparam logic [7:0] DS_LINE_MASK = 8'h56;
    localparam logic [7:0] DS_SEEK_DONE = 8'h20;
    localparam int DS_READY_BIT = 1;
    localparam int DS_WP_BIT    = 2;
    localparam logic [7:0] SEL_NONE = 8'hFF;

    // drive actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_STEP_IN  = 3'd1;
    localparam logic [2:0] ACT_STEP_OUT = 3'd2;
    localparam logic [2:0] ACT_RESTORE  = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;
    localparam logic [2:0] ACT_WRITE    = 3'd5;

    localparam logic [10:0] SECTOR_BASE_BYTES = 11'd128;

    // command classes
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_DESELECT,
        CMD_RESTORE,
        CMD_STEP_IN,
        CMD_STEP_OUT,
        CMD_SELECT,
        CMD_SET_PTR,
        CMD_READ_LOG,
        CMD_WRITE_LOG
    } cmd_kind_t;

    // one bus access
    typedef struct packed {
        logic       command;
        logic       port;
        logic [7:0] write_data;
        logic [7:0] drive_lines;
        logic       sector_found;
        logic [1:0] size_code;
    } access_t;

    // one answer
    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic [2:0]  drive_action;
        logic [1:0]  drive_unit;
        logic [10:0] cylinder_number;
        logic [3:0]  head_number;
        logic [7:0]  sector_number;
        logic [23:0] transfer_address;
        logic [10:0] transfer_bytes;
    } result_t;

    // command byte decoder
    function automatic cmd_kind_t cmd_decode(input logic [7:0] op);
        cmd_kind_t kind;
        unique case (op) inside
            8'h01:          kind = CMD_DESELECT;
            8'h02, 8'h03:   kind = CMD_RESTORE;
            8'h04, 8'h05:   kind = CMD_STEP_IN;
            8'h06, 8'h07:   kind = CMD_STEP_OUT;
            [8'h20:8'h2F]:  kind = CMD_SELECT;
            [8'h40:8'h4F]:  kind = CMD_SET_PTR;
            [8'h5C:8'h5F]:  kind = CMD_READ_LOG;
            [8'hA0:8'hBF]:  kind = CMD_WRITE_LOG;
            default:        kind = CMD_NONE;
        endcase
        return kind;
    endfunction

endpackage

// ----- rtl/core/dcri_input_stage.sv -----
// input register of the access pipeline
// depends on dcri_pkg for the access struct

module dcri_input_stage
    import dcri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  access_t in_beat,
    output logic    in_stall,
    input  logic    advance,
    output logic    held_valid,
    output access_t held_beat
);

    logic    valid_reg;
    logic    valid_next;
    access_t beat_reg;
    logic    accept;

    // take a new beat when empty or when the held one moves on
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload holds without reset
    always_ff @(posedge clk)
    begin
        if (accept)
            beat_reg <= in_beat;
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

// ----- rtl/core/dcri_core.sv -----
// controller state and single-pass access decode
// depends on dcri_pkg for codes, layout constants and the command decoder

module dcri_core
    import dcri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  access_t beat,
    output result_t result
);

    logic [7:0]          status_reg, status_next;
    logic [7:0]          select_reg, select_next;
    logic [7:0]          rf_reg [RF_DEPTH];
    logic [7:0]          rf_next [RF_DEPTH];
    logic [RF_IDX_W-1:0] ptr_reg, ptr_next;
    logic                irq_reg, irq_next;

    // selected drive view
    logic       unit_ok;
    logic       floppy;
    logic [1:0] unit;
    logic [7:0] drv_stat;

    assign unit_ok  = (select_reg != SEL_NONE) && (select_reg[3:2] != 2'd0)
                      && (select_reg[1:0] != 2'd0);
    assign floppy   = select_reg[3];
    assign unit     = select_reg[1:0] - 2'd1;
    assign drv_stat = (unit_ok && floppy) ? ((beat.drive_lines & DS_LINE_MASK) | DS_SEEK_DONE)
                                          : 8'h00;

    // access decode and next state
    always_comb
    begin
        cmd_kind_t           kind;
        logic                do_done;
        logic [7:0]          st_pre;
        logic [23:0]         addr;
        logic [23:0]         addr_new;
        logic [10:0]         bytes;
        logic                drv_err;
        logic [RF_IDX_W-1:0] rd_idx;

        status_next = status_reg;
        select_next = select_reg;
        ptr_next    = ptr_reg;
        irq_next    = irq_reg;
        for (int i = 0; i < RF_DEPTH; i++)
            rf_next[i] = rf_reg[i];
        result   = '0;
        do_done  = 1'b0;
        st_pre   = status_reg;
        kind     = cmd_decode(beat.write_data);
        addr     = {rf_reg[RF_ADDR_HI], rf_reg[RF_ADDR_MID], rf_reg[RF_ADDR_LO]};
        addr_new = addr;
        bytes    = SECTOR_BASE_BYTES << beat.size_code;
        drv_err  = !unit_ok || !drv_stat[DS_READY_BIT]
                   || (rf_reg[RF_TERM][TERM_WP_BIT] && drv_stat[DS_WP_BIT]);
        rd_idx   = (ptr_reg < PTR_STAT_MAP) ? ptr_reg : ptr_reg + PTR_STAT_OFS;

        if (beat.command && beat.port)
        begin
            case (kind)
                CMD_DESELECT:
                begin
                    select_next = SEL_NONE;
                    do_done     = 1'b1;
                end
                CMD_SELECT:
                begin
                    select_next = {4'h0, beat.write_data[3:0]};
                    do_done     = 1'b1;
                end
                CMD_SET_PTR:
                begin
                    ptr_next = beat.write_data[3:0];
                    do_done  = 1'b1;
                end
                CMD_RESTORE, CMD_STEP_IN, CMD_STEP_OUT:
                begin
                    st_pre  = 8'h00;
                    do_done = 1'b1;
                    if (unit_ok && floppy)
                    begin
                        result.drive_unit = unit;
                        if (kind == CMD_RESTORE)
                            result.drive_action = ACT_RESTORE;
                        else if (kind == CMD_STEP_IN)
                            result.drive_action = ACT_STEP_IN;
                        else
                            result.drive_action = ACT_STEP_OUT;
                    end
                    rf_next[RF_CHIP_STAT] = {6'h00, select_reg[1:0]};
                    rf_next[RF_DRV_STAT]  = drv_stat;
                end
                CMD_READ_LOG, CMD_WRITE_LOG:
                begin
                    st_pre  = 8'h00;
                    do_done = 1'b1;
                    if (drv_err)
                        st_pre = ST_CODE_ERR;
                    else
                    begin
                        result.drive_action     = (kind == CMD_WRITE_LOG) ? ACT_WRITE
                                                                          : ACT_READ;
                        result.drive_unit       = unit;
                        result.cylinder_number  = {rf_reg[RF_HEAD_CYL][6:4],
                                                   rf_reg[RF_CYL_LO]};
                        result.head_number      = rf_reg[RF_HEAD_CYL][3:0];
                        result.sector_number    = rf_reg[RF_SECTOR];
                        result.transfer_address = addr;
                        if (beat.sector_found)
                        begin
                            result.transfer_bytes = bytes;
                            addr_new = addr + {13'h0000, bytes};
                        end
                        else
                            st_pre = ST_CODE_ERR;
                    end
                    rf_next[RF_ADDR_LO]   = addr_new[7:0];
                    rf_next[RF_ADDR_MID]  = addr_new[15:8];
                    rf_next[RF_ADDR_HI]   = addr_new[23:16];
                    rf_next[RF_CHIP_STAT] = {6'h00, select_reg[1:0]};
                    rf_next[RF_DRV_STAT]  = drv_stat;
                end
                default:
                begin
                end
            endcase
        end
        else if (beat.command)
        begin
            // data port write through the pointer
            if (ptr_reg < PTR_LIMIT)
            begin
                rf_next[ptr_reg] = beat.write_data;
                ptr_next         = ptr_reg + 4'd1;
            end
        end
        else if (beat.port)
        begin
            // status read clears pending
            result.read_data = status_reg;
            if (status_reg[7])
            begin
                status_next = status_reg & ~ST_PENDING;
                irq_next    = 1'b0;
            end
        end
        else if (ptr_reg < PTR_LIMIT)
        begin
            result.read_data = rf_reg[rd_idx];
            ptr_next         = ptr_reg + 4'd1;
        end

        // completion raises done and maybe the interrupt
        if (do_done)
        begin
            status_next = st_pre | ST_DONE;
            if (rf_reg[RF_TERM][TERM_IRQ_BIT] && !st_pre[7])
            begin
                status_next = status_next | ST_PENDING;
                irq_next    = 1'b1;
            end
        end

        result.irq = irq_next;
    end

    // state update per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            select_reg <= 8'h00;
            ptr_reg    <= '0;
            irq_reg    <= 1'b0;
            for (int i = 0; i < RF_DEPTH; i++)
                rf_reg[i] <= 8'h00;
        end
        else if (fire)
        begin
            status_reg <= status_next;
            select_reg <= select_next;
            ptr_reg    <= ptr_next;
            irq_reg    <= irq_next;
            for (int i = 0; i < RF_DEPTH; i++)
                rf_reg[i] <= rf_next[i];
        end
    end

`ifndef SYNTHESIS
    // interrupt only rises together with pending
    a_irq_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_reg) |-> status_reg[7])
        else $error("irq rose without pending status");

    // pending is always accompanied by done
    a_pending_done: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[7] |-> status_reg[5])
        else $error("pending set without done");

    // data access beyond the file leaves the pointer alone
    a_ptr_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !beat.port && (ptr_reg >= PTR_LIMIT)) |=> $stable(ptr_reg))
        else $error("pointer advanced past the file");

    // bytes only move on a transfer action
    a_bytes_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (result.transfer_bytes != 11'd0)) |->
        ((result.drive_action == ACT_READ) || (result.drive_action == ACT_WRITE)))
        else $error("transfer bytes without transfer action");
`endif

endmodule

// ----- rtl/core/dcri_output_stage.sv -----
// result register of the access pipeline
// depends on dcri_pkg for the result struct

module dcri_output_stage
    import dcri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_result,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // a waiting beat stays until taken
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= load_result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- rtl/core/disk_controller_register_interface_unit.sv -----
// Path: an access beat is held in the input register, then decoded into the result register.
// Throughput: one access per cycle; the input register hands its beat to the
// result register whenever that register is empty or being drained.
// Reset (rst_n low, asynchronous): status, drive select, pointer, interrupt and
// the whole register file clear to zero; both pipeline registers empty.
// Top level: input stage, decode core and output stage from dcri_pkg types.

module disk_controller_register_interface_unit
    import dcri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic        port,
    input  logic [7:0]  write_data,
    input  logic [7:0]  drive_lines,
    input  logic        sector_found,
    input  logic [1:0]  size_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        irq,
    output logic [2:0]  drive_action,
    output logic [1:0]  drive_unit,
    output logic [10:0] cylinder_number,
    output logic [3:0]  head_number,
    output logic [7:0]  sector_number,
    output logic [23:0] transfer_address,
    output logic [10:0] transfer_bytes
);

    access_t in_beat;
    access_t held_beat;
    logic    held_valid;
    logic    advance;
    result_t core_result;
    result_t out_result;

    assign in_beat = '{command:      command,
                       port:         port,
                       write_data:   write_data,
                       drive_lines:  drive_lines,
                       sector_found: sector_found,
                       size_code:    size_code};

    // held beat moves on when the result register can take it
    assign advance = held_valid && (!out_valid || !out_stall);

    dcri_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_beat    (in_beat),
        .in_stall   (in_stall),
        .advance    (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    dcri_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .beat   (held_beat),
        .result (core_result)
    );

    dcri_output_stage u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (core_result),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_result  (out_result)
    );

    assign read_data        = out_result.read_data;
    assign irq              = out_result.irq;
    assign drive_action     = out_result.drive_action;
    assign drive_unit       = out_result.drive_unit;
    assign cylinder_number  = out_result.cylinder_number;
    assign head_number      = out_result.head_number;
    assign sector_number    = out_result.sector_number;
    assign transfer_address = out_result.transfer_address;
    assign transfer_bytes   = out_result.transfer_bytes;

endmodule

// ----- tb/tb_top.sv -----
// testbench for disk_controller_register_interface_unit: bus access beats in, answer beats out
// predicts every answer with a local mirror of the register state; depends on dcri_pkg and the top module

module tb_top;
    import dcri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // access kinds and ports
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CTRL = 1'b1;

    // command bytes, low bits filled in where the command carries an operand
    localparam logic [7:0] OP_DESELECT  = 8'h01;
    localparam logic [7:0] OP_RESTORE   = 8'h02;
    localparam logic [7:0] OP_STEP_IN   = 8'h04;
    localparam logic [7:0] OP_STEP_OUT  = 8'h06;
    localparam logic [7:0] OP_SELECT    = 8'h20;
    localparam logic [7:0] OP_SET_PTR   = 8'h40;
    localparam logic [7:0] OP_UNUSED    = 8'h58;
    localparam logic [7:0] OP_READ_LOG  = 8'h5C;
    localparam logic [7:0] OP_WRITE_LOG = 8'hA0;

    // select operands: mode in bits 3:2, unit bits in 1:0
    localparam logic [3:0] SEL_FLOPPY_U0 = 4'hD;
    localparam logic [3:0] SEL_HARD_U0   = 4'h5;

    // termination byte with interrupt and write protect checks enabled
    localparam logic [7:0] TERM_IRQ_WP = 8'((1 << TERM_IRQ_BIT) | (1 << TERM_WP_BIT));
    localparam logic [7:0] LINE_READY  = 8'(1 << DS_READY_BIT);
    localparam logic [7:0] LINE_WP     = 8'(1 << DS_WP_BIT);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic        port = 1'b0;
    logic [7:0]  write_data = 8'h00;
    logic [7:0]  drive_lines = 8'h00;
    logic        sector_found = 1'b0;
    logic [1:0]  size_code = 2'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        irq;
    logic [2:0]  drive_action;
    logic [1:0]  drive_unit;
    logic [10:0] cylinder_number;
    logic [3:0]  head_number;
    logic [7:0]  sector_number;
    logic [23:0] transfer_address;
    logic [10:0] transfer_bytes;

    int      errors = 0;
    int      items_sent = 0;
    bit      quiet = 1'b0;
    int      stall_hold = 0;
    result_t answer_queue[$];

    // mirror of the register state
    logic [7:0] mir_status = 8'h00;
    logic [7:0] mir_select = 8'h00;
    logic [7:0] mir_regs [RF_DEPTH] = '{default: 8'h00};
    logic [3:0] mir_ptr = 4'd0;
    logic       mir_irq = 1'b0;

    disk_controller_register_interface_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .port             (port),
        .write_data       (write_data),
        .drive_lines      (drive_lines),
        .sector_found     (sector_found),
        .size_code        (size_code),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .irq              (irq),
        .drive_action     (drive_action),
        .drive_unit       (drive_unit),
        .cylinder_number  (cylinder_number),
        .head_number      (head_number),
        .sector_number    (sector_number),
        .transfer_address (transfer_address),
        .transfer_bytes   (transfer_bytes)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // done sets pending and the line only when the interrupt condition is enabled
    function automatic void mark_done();
        mir_status |= ST_DONE;
        if (mir_regs[RF_TERM][TERM_IRQ_BIT] && (mir_status & ST_PENDING) == 8'h00)
        begin
            mir_status |= ST_PENDING;
            mir_irq = 1'b1;
        end
    endfunction

    // selected unit, -1 when no drive
    function automatic int sel_unit();
        if (mir_select == SEL_NONE || mir_select[3:2] == 2'd0 || mir_select[1:0] == 2'd0)
            return -1;
        return int'(mir_select[1:0]) - 1;
    endfunction

    // drive status byte: floppy lines plus seek complete, zero otherwise
    function automatic logic [7:0] drv_status(input int unit, input logic [7:0] lines);
        if (unit < 0 || mir_select[3:2] < 2'd2)
            return 8'h00;
        return (lines & DS_LINE_MASK) | DS_SEEK_DONE;
    endfunction

    // restore and step commands
    function automatic void do_seek(input logic [2:0] action, input access_t a,
                                    inout result_t r);
        int unit;
        unit = sel_unit();
        mir_status = 8'h00;
        if (unit >= 0 && mir_select[3:2] >= 2'd2)
        begin
            r.drive_action = action;
            r.drive_unit = unit[1:0];
        end
        mark_done();
        mir_regs[RF_CHIP_STAT] = {6'd0, mir_select[1:0]};
        mir_regs[RF_DRV_STAT] = drv_status(unit, a.drive_lines);
    endfunction

    // logical read and write: drive checks, chs forming, address advance
    function automatic void do_logical(input logic writing, input access_t a,
                                       inout result_t r);
        logic [23:0] addr;
        logic [7:0]  ds;
        logic [10:0] nbytes;
        int          unit;
        addr = {mir_regs[RF_ADDR_HI], mir_regs[RF_ADDR_MID], mir_regs[RF_ADDR_LO]};
        unit = sel_unit();
        ds = drv_status(unit, a.drive_lines);
        mir_status = 8'h00;
        if (unit < 0 || !ds[DS_READY_BIT] || (mir_regs[RF_TERM][TERM_WP_BIT] && ds[DS_WP_BIT]))
        begin
            mir_status |= ST_CODE_ERR;
        end
        else
        begin
            r.drive_action = writing ? ACT_WRITE : ACT_READ;
            r.drive_unit = unit[1:0];
            r.cylinder_number = {mir_regs[RF_HEAD_CYL][6:4], mir_regs[RF_CYL_LO]};
            r.head_number = mir_regs[RF_HEAD_CYL][3:0];
            r.sector_number = mir_regs[RF_SECTOR];
            r.transfer_address = addr;
            if (a.sector_found)
            begin
                nbytes = SECTOR_BASE_BYTES << a.size_code;
                r.transfer_bytes = nbytes;
                addr = addr + 24'(nbytes);
            end
            else
            begin
                mir_status |= ST_CODE_ERR;
            end
        end
        mark_done();
        mir_regs[RF_ADDR_LO] = addr[7:0];
        mir_regs[RF_ADDR_MID] = addr[15:8];
        mir_regs[RF_ADDR_HI] = addr[23:16];
        mir_regs[RF_CHIP_STAT] = {6'd0, mir_select[1:0]};
        mir_regs[RF_DRV_STAT] = ds;
    endfunction

    // command byte decode on the mirror
    function automatic void run_op(input access_t a, inout result_t r);
        logic [7:0] op;
        op = a.write_data;
        if (op == OP_DESELECT)
        begin
            mir_select = SEL_NONE;
            mark_done();
        end
        else if (op[7:1] == OP_RESTORE[7:1])
            do_seek(ACT_RESTORE, a, r);
        else if (op[7:2] == OP_STEP_IN[7:2])
            do_seek(op[1] ? ACT_STEP_OUT : ACT_STEP_IN, a, r);
        else if (op[7:4] == OP_SELECT[7:4])
        begin
            mir_select = {4'h0, op[3:0]};
            mark_done();
        end
        else if (op[7:4] == OP_SET_PTR[7:4])
        begin
            mir_ptr = op[3:0];
            mark_done();
        end
        else if (op[7:2] == OP_READ_LOG[7:2])
            do_logical(1'b0, a, r);
        else if (op[7:5] == OP_WRITE_LOG[7:5])
            do_logical(1'b1, a, r);
    endfunction

    // expected answer of one access beat, advancing the mirror
    function automatic result_t predict_access(input access_t a);
        result_t r;
        r = '0;
        if (a.command == ACC_WRITE)
        begin
            if (a.port == PORT_CTRL)
                run_op(a, r);
            else if (mir_ptr < PTR_LIMIT)
            begin
                mir_regs[mir_ptr] = a.write_data;
                mir_ptr++;
            end
        end
        else if (a.port == PORT_CTRL)
        begin
            r.read_data = mir_status;
            if ((mir_status & ST_PENDING) != 8'h00)
            begin
                mir_status &= ~ST_PENDING;
                mir_irq = 1'b0;
            end
        end
        else if (mir_ptr < PTR_LIMIT)
        begin
            r.read_data = mir_regs[(mir_ptr < PTR_STAT_MAP) ? mir_ptr : mir_ptr + PTR_STAT_OFS];
            mir_ptr++;
        end
        r.irq = mir_irq;
        return r;
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int idle_cycles();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic access_t acc(input logic cmd, input logic prt, input logic [7:0] data,
                                    input logic [7:0] lines, input logic found,
                                    input logic [1:0] size);
        access_t a;
        a.command = cmd;
        a.port = prt;
        a.write_data = data;
        a.drive_lines = lines;
        a.sector_found = found;
        a.size_code = size;
        return a;
    endfunction

    function automatic access_t rand_access(input logic cmd, input logic prt,
                                            input logic [7:0] data);
        return acc(cmd, prt, data, 8'($urandom), 1'($urandom), 2'($urandom));
    endfunction

    // drive one access beat, hold it until accepted, then log its answer
    task automatic send_beat(input access_t a);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= a.command;
        port <= a.port;
        write_data <= a.write_data;
        drive_lines <= a.drive_lines;
        sector_found <= a.sector_found;
        size_code <= a.size_code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        answer_queue.push_back(predict_access(a));
        items_sent++;
    endtask

    task automatic send_ctrl(input logic [7:0] op);
        send_beat(rand_access(ACC_WRITE, PORT_CTRL, op));
    endtask

    task automatic send_data(input logic [7:0] b);
        send_beat(rand_access(ACC_WRITE, PORT_DATA, b));
    endtask

    task automatic read_port(input logic prt);
        send_beat(rand_access(ACC_READ, prt, 8'($urandom)));
    endtask

    // random command byte, mostly decodable ones
    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 8))
            0: return OP_DESELECT;
            1: return OP_RESTORE | 8'($urandom_range(0, 1));
            2: return OP_STEP_IN | 8'($urandom_range(0, 3));
            3: return OP_SELECT | 8'($urandom_range(0, 15));
            4: return OP_SET_PTR | 8'($urandom_range(0, 15));
            5: return OP_READ_LOG | 8'($urandom_range(0, 3));
            6: return OP_WRITE_LOG | 8'($urandom_range(0, 31));
            7: return OP_UNUSED | 8'($urandom_range(0, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    // one well-formed transfer: optional select and termination setup, chs and
    // address load, logical command, then status and register readback
    task automatic run_transfer();
        logic [3:0] sel;
        logic [7:0] op;
        logic [7:0] lines;
        int         i;
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                sel = 4'($urandom);
            else
                sel = {2'($urandom_range(2, 3)), 2'($urandom_range(1, 3))};
            send_ctrl(OP_SELECT | 8'(sel));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_ctrl(OP_SET_PTR | 8'(RF_TERM));
            send_data(8'($urandom));
        end
        send_ctrl(OP_SET_PTR | 8'(RF_ADDR_LO));
        for (i = 0; i < 6; i++)
            send_data(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom));
        lines = ($urandom_range(0, 4) == 0) ? 8'($urandom) : (8'($urandom) | LINE_READY);
        if ($urandom_range(0, 1) == 1)
            op = OP_READ_LOG | 8'($urandom_range(0, 3));
        else
            op = OP_WRITE_LOG | 8'($urandom_range(0, 31));
        send_beat(acc(ACC_WRITE, PORT_CTRL, op, lines, $urandom_range(0, 5) != 0,
                      2'($urandom)));
        if ($urandom_range(0, 1) == 1)
            read_port(PORT_CTRL);
        if ($urandom_range(0, 1) == 1)
        begin
            send_ctrl(OP_SET_PTR | 8'(RF_ADDR_LO));
            repeat (3) read_port(PORT_DATA);
        end
        else
        begin
            send_ctrl(OP_SET_PTR | 8'(PTR_STAT_MAP));
            repeat (3) read_port(PORT_DATA);
        end
    endtask

    // registers read zero after reset
    task automatic test_reset_state();
        read_port(PORT_CTRL);
        read_port(PORT_DATA);
    endtask

    // pointer wrap into status copies, pointer past nine, termination setup
    task automatic test_register_file();
        send_ctrl(OP_SET_PTR | 8'(PTR_STAT_MAP));
        send_beat(acc(ACC_WRITE, PORT_DATA, 8'h00, 8'h00, 1'b0, 2'd0));
        send_data(TERM_IRQ_WP);
        send_beat(acc(ACC_WRITE, PORT_DATA, 8'hFF, 8'hFF, 1'b1, 2'd3));
        send_ctrl(OP_SET_PTR | 8'(PTR_STAT_MAP));
        repeat (3) read_port(PORT_DATA);
        send_ctrl(OP_SET_PTR | 8'h0F);
        read_port(PORT_DATA);
    endtask

    // every command and each drive check outcome
    task automatic test_command_set();
        // no drive after deselect, interrupt raised and dropped by status read
        send_ctrl(OP_DESELECT);
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_READ_LOG, 8'hFF, 1'b1, 2'd0));
        read_port(PORT_CTRL);
        // floppy unit 0, address close to the top of the space
        send_ctrl(OP_SELECT | 8'(SEL_FLOPPY_U0));
        send_ctrl(OP_SET_PTR | 8'(RF_ADDR_LO));
        send_data(8'h80);
        repeat (5) send_data(8'hFF);
        // with the check enabled, write protect fails writes and reads alike
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_WRITE_LOG, LINE_READY | LINE_WP, 1'b1, 2'd0));
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_READ_LOG | 8'h03, 8'hFF, 1'b1, 2'd3));
        // largest sector, address wraps past the top
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_READ_LOG | 8'h01, LINE_READY, 1'b1, 2'd3));
        // sector not found
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_WRITE_LOG | 8'h1F, ~LINE_WP, 1'b0, 2'd0));
        // head movement
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_RESTORE | 8'h01, 8'h00, 1'b0, 2'd0));
        send_ctrl(OP_STEP_IN | 8'h01);
        send_ctrl(OP_STEP_OUT | 8'h01);
        // hard disk is never ready
        send_ctrl(OP_SELECT | 8'(SEL_HARD_U0));
        send_beat(acc(ACC_WRITE, PORT_CTRL, OP_READ_LOG | 8'h02, 8'hFF, 1'b1, 2'd1));
        // undecoded command bytes
        send_ctrl(8'hFF);
        send_ctrl(OP_UNUSED);
        send_ctrl(8'h00);
        read_port(PORT_CTRL);
    endtask

    // mostly well-formed transfers with random content
    task automatic test_transfer_sequences();
        int stop_at;
        stop_at = items_sent + 600;
        while (items_sent < stop_at)
            run_transfer();
    endtask

    // random accesses of any kind
    task automatic test_bus_noise();
        int i;
        for (i = 0; i < 150; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_beat(rand_access(1'($urandom), 1'($urandom), 8'($urandom)));
                4, 5, 6:    send_ctrl(pick_op());
                7, 8:       read_port(PORT_DATA);
                default:    read_port(PORT_CTRL);
            endcase
        end
    endtask

    // transfers with no idling on either side
    task automatic test_back_to_back();
        int stop_at;
        quiet = 1'b1;
        stop_at = items_sent + 80;
        while (items_sent < stop_at)
            run_transfer();
        quiet = 1'b0;
    endtask

    // answer side stall pattern
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_stall <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
            stall_hold--;
        else
        begin
            out_stall <= 1'($urandom_range(0, 1));
            stall_hold = idle_cycles();
        end
    end

    task automatic check_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // compare each accepted answer beat with the oldest prediction
    always @(posedge clk)
    begin : answer_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_queue.size() == 0)
            begin
                $display("%0t: answer beat with none expected, actual read_data %0h",
                         $time, read_data);
                errors++;
            end
            else
            begin
                want = answer_queue.pop_front();
                check_field("read_data", 24'(want.read_data), 24'(read_data));
                check_field("irq", 24'(want.irq), 24'(irq));
                check_field("drive_action", 24'(want.drive_action), 24'(drive_action));
                check_field("drive_unit", 24'(want.drive_unit), 24'(drive_unit));
                check_field("cylinder_number", 24'(want.cylinder_number),
                            24'(cylinder_number));
                check_field("head_number", 24'(want.head_number), 24'(head_number));
                check_field("sector_number", 24'(want.sector_number), 24'(sector_number));
                check_field("transfer_address", want.transfer_address, transfer_address);
                check_field("transfer_bytes", 24'(want.transfer_bytes), 24'(transfer_bytes));
            end
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_register_file();
        test_command_set();
        test_transfer_sequences();
        test_bus_noise();
        test_back_to_back();
        in_valid <= 1'b0;
        wait (answer_queue.size() == 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- disk_controller_register_interface_unit.f -----
rtl/core/dcri_pkg.sv
rtl/core/dcri_input_stage.sv
rtl/core/dcri_core.sv
rtl/core/dcri_output_stage.sv
rtl/core/disk_controller_register_interface_unit.sv
tb/tb_top.sv
